@@ design/bis_pkg.sv @@
// bis_pkg: sizes, codes and the control word type shared by the scaler modules
// no dependencies
package bis_pkg;

    localparam int MAX_SRC_WIDTH  = 512;
    localparam int MAX_SRC_HEIGHT = 512;
    localparam int MAX_DEST_DIM   = 4096;
    localparam int FRAC_BITS      = 8;

    // stream field widths
    localparam int COORD_W    = 12;
    localparam int PIX_W      = 8;
    localparam int IN_FIELD_W = 2 * COORD_W + PIX_W;
    localparam int IN_DATA_W  = ((IN_FIELD_W + 7) / 8) * 8;

    // configuration port
    localparam int SRC_CFG_W  = 10;
    localparam int DST_CFG_W  = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 2'd3;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    // effective dimension and index widths
    localparam int SW_W = $clog2(MAX_SRC_WIDTH + 1);
    localparam int SH_W = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int SD_W = (SW_W > SH_W) ? SW_W : SH_W;
    localparam int TD_W = $clog2(MAX_DEST_DIM + 1);
    localparam int XA_W = $clog2(MAX_SRC_WIDTH);
    localparam int YA_W = $clog2(MAX_SRC_HEIGHT);

    // fixed point source position: dividend and quotient width
    localparam int DIV_W = COORD_W + SD_W + FRAC_BITS;

    typedef struct packed {
        logic              cmd;
        logic              wr_ok;
        logic [XA_W-1:0]   lx;
        logic [YA_W-1:0]   ly;
        logic [PIX_W-1:0]  pix;
    } t_ctl;

endpackage

@@ design/bis_div.sv @@
// bis_div: pipelined restoring divider for both axes, one quotient bit per stage
// depends on bis_pkg; carries the control word and valid bit alongside
module bis_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  bis_pkg::t_ctl               i_ctl,
    input  logic [bis_pkg::DIV_W-1:0]   i_num_x,
    input  logic [bis_pkg::DIV_W-1:0]   i_num_y,
    input  logic [bis_pkg::TD_W-1:0]    i_den_x,
    input  logic [bis_pkg::TD_W-1:0]    i_den_y,
    output logic                        o_vld,
    output bis_pkg::t_ctl               o_ctl,
    output logic [bis_pkg::DIV_W-1:0]   o_quo_x,
    output logic [bis_pkg::DIV_W-1:0]   o_quo_y
);
    import bis_pkg::*;

    typedef struct packed {
        logic [TD_W-1:0] rem;
        logic            q;
    } t_step;

    function automatic t_step div_step(input logic [TD_W-1:0] rem, input logic nbit,
                                       input logic [TD_W-1:0] den);
        logic [TD_W:0] sh;
        t_step         s;
        sh = {rem, nbit};
        if (sh >= {1'b0, den}) begin
            s.q   = 1'b1;
            s.rem = TD_W'(sh - {1'b0, den});
        end else begin
            s.q   = 1'b0;
            s.rem = sh[TD_W-1:0];
        end
        return s;
    endfunction

    logic [DIV_W-1:0] r_vld;
    t_ctl             r_ctl   [DIV_W];
    logic [DIV_W-1:0] r_num_x [DIV_W];
    logic [DIV_W-1:0] r_num_y [DIV_W];
    logic [DIV_W-1:0] r_quo_x [DIV_W];
    logic [DIV_W-1:0] r_quo_y [DIV_W];
    logic [TD_W-1:0]  r_rem_x [DIV_W];
    logic [TD_W-1:0]  r_rem_y [DIV_W];

    t_ctl             n_ctl   [DIV_W];
    logic [DIV_W-1:0] n_num_x [DIV_W];
    logic [DIV_W-1:0] n_num_y [DIV_W];
    logic [DIV_W-1:0] n_quo_x [DIV_W];
    logic [DIV_W-1:0] n_quo_y [DIV_W];
    logic [TD_W-1:0]  n_rem_x [DIV_W];
    logic [TD_W-1:0]  n_rem_y [DIV_W];

    for (genvar k = 0; k < DIV_W; k++) begin : g_stage
        logic [DIV_W-1:0] num_in_x, num_in_y, quo_in_x, quo_in_y;
        logic [TD_W-1:0]  rem_in_x, rem_in_y;
        t_ctl             ctl_in;
        t_step            sx, sy;

        if (k == 0) begin : g_first
            assign num_in_x = i_num_x;
            assign num_in_y = i_num_y;
            assign quo_in_x = '0;
            assign quo_in_y = '0;
            assign rem_in_x = '0;
            assign rem_in_y = '0;
            assign ctl_in   = i_ctl;
        end else begin : g_next
            assign num_in_x = r_num_x[k-1];
            assign num_in_y = r_num_y[k-1];
            assign quo_in_x = r_quo_x[k-1];
            assign quo_in_y = r_quo_y[k-1];
            assign rem_in_x = r_rem_x[k-1];
            assign rem_in_y = r_rem_y[k-1];
            assign ctl_in   = r_ctl[k-1];
        end

        assign sx = div_step(rem_in_x, num_in_x[DIV_W-1], i_den_x);
        assign sy = div_step(rem_in_y, num_in_y[DIV_W-1], i_den_y);

        assign n_rem_x[k] = sx.rem;
        assign n_rem_y[k] = sy.rem;
        assign n_num_x[k] = num_in_x << 1;
        assign n_num_y[k] = num_in_y << 1;
        assign n_quo_x[k] = {quo_in_x[DIV_W-2:0], sx.q};
        assign n_quo_y[k] = {quo_in_y[DIV_W-2:0], sy.q};
        assign n_ctl[k]   = ctl_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_W-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_W; k++) begin
                r_ctl[k]   <= n_ctl[k];
                r_num_x[k] <= n_num_x[k];
                r_num_y[k] <= n_num_y[k];
                r_quo_x[k] <= n_quo_x[k];
                r_quo_y[k] <= n_quo_y[k];
                r_rem_x[k] <= n_rem_x[k];
                r_rem_y[k] <= n_rem_y[k];
            end
        end
    end

    assign o_vld   = r_vld[DIV_W-1];
    assign o_ctl   = r_ctl[DIV_W-1];
    assign o_quo_x = r_quo_x[DIV_W-1];
    assign o_quo_y = r_quo_y[DIV_W-1];

endmodule

@@ design/bis_store.sv @@
// bis_store: source image store in four banks split by column and row parity
// depends on bis_pkg; one write and four neighbour reads per cycle, reads only while i_en is high, read data registered
module bis_store (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic                       i_wr,
    input  logic [bis_pkg::XA_W-1:0]   i_wx,
    input  logic [bis_pkg::YA_W-1:0]   i_wy,
    input  logic [bis_pkg::PIX_W-1:0]  i_wpix,
    input  logic [bis_pkg::XA_W-1:0]   i_x0,
    input  logic [bis_pkg::XA_W-1:0]   i_x1,
    input  logic [bis_pkg::YA_W-1:0]   i_y0,
    input  logic [bis_pkg::YA_W-1:0]   i_y1,
    output logic [bis_pkg::PIX_W-1:0]  o_nw,
    output logic [bis_pkg::PIX_W-1:0]  o_ne,
    output logic [bis_pkg::PIX_W-1:0]  o_sw,
    output logic [bis_pkg::PIX_W-1:0]  o_se
);
    import bis_pkg::*;

    localparam int XH_W       = (XA_W > 1) ? XA_W - 1 : 1;
    localparam int YH_W       = (YA_W > 1) ? YA_W - 1 : 1;
    localparam int BANK_AW    = XH_W + YH_W;
    localparam int BANK_DEPTH = 2 ** BANK_AW;

    logic [PIX_W-1:0]   r_rd [4];
    logic               r_x0p, r_x1p, r_y0p, r_y1p;
    logic [BANK_AW-1:0] waddr;

    assign waddr = {YH_W'(i_wy >> 1), XH_W'(i_wx >> 1)};

    // neighbours in x (and in y) differ in parity unless clamped, then they are the same pixel
    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic BX = logic'(b % 2);
        localparam logic BY = logic'(b / 2);

        logic [PIX_W-1:0]   r_mem [BANK_DEPTH];
        logic [BANK_AW-1:0] raddr;
        logic               wen;

        assign raddr = {(i_y0[0] == BY) ? YH_W'(i_y0 >> 1) : YH_W'(i_y1 >> 1),
                        (i_x0[0] == BX) ? XH_W'(i_x0 >> 1) : XH_W'(i_x1 >> 1)};
        assign wen   = i_wr && (i_wx[0] == BX) && (i_wy[0] == BY);

        always_ff @(posedge i_clk) begin
            if (wen) begin
                r_mem[waddr] <= i_wpix;
            end
            if (i_en) begin
                r_rd[b] <= r_mem[raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x0p <= i_x0[0];
            r_x1p <= i_x1[0];
            r_y0p <= i_y0[0];
            r_y1p <= i_y1[0];
        end
    end

    assign o_nw = r_y0p ? (r_x0p ? r_rd[3] : r_rd[2]) : (r_x0p ? r_rd[1] : r_rd[0]);
    assign o_ne = r_y0p ? (r_x1p ? r_rd[3] : r_rd[2]) : (r_x1p ? r_rd[1] : r_rd[0]);
    assign o_sw = r_y1p ? (r_x0p ? r_rd[3] : r_rd[2]) : (r_x0p ? r_rd[1] : r_rd[0]);
    assign o_se = r_y1p ? (r_x1p ? r_rd[3] : r_rd[2]) : (r_x1p ? r_rd[1] : r_rd[0]);

endmodule

@@ design/bilinear_image_scaler.sv @@
// bilinear_image_scaler: top level; uses bis_pkg, bis_div and bis_store
// stages in order: scaling, divider, clamp, store read, horizontal blend, output queue
// throughput: one load or compute word per cycle while the output queue is not full, set by the
//   one-bit-per-stage divider pipeline and the four parity banks of the image store (four reads each cycle)
// reset: synchronous, active low; clears valid bits, the output queue and the dimension
//   registers (512 each); the image store is not cleared and holds nothing until loaded
module bilinear_image_scaler (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [bis_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // coord_x, coord_y, pixel_in
    input  logic                             s_axis_tuser,  // command
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [bis_pkg::PIX_W-1:0]        m_axis_tdata,  // pixel_out
    input  logic                             i_cfg_we,
    input  logic [bis_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bis_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bis_pkg::*;

    localparam int SRC_W_RST = (512 > MAX_SRC_WIDTH) ? MAX_SRC_WIDTH : 512;
    localparam int SRC_H_RST = (512 > MAX_SRC_HEIGHT) ? MAX_SRC_HEIGHT : 512;
    localparam int DST_RST   = (512 > MAX_DEST_DIM) ? MAX_DEST_DIM : 512;
    localparam int PX_W      = COORD_W + SW_W;
    localparam int PY_W      = COORD_W + SH_W;
    localparam int IP_W      = DIV_W - FRAC_BITS;
    localparam int WT_W      = FRAC_BITS + 1;
    localparam int TOP_W     = PIX_W + FRAC_BITS;
    localparam int ACC_W     = PIX_W + 2 * FRAC_BITS;
    localparam int ONE       = 2 ** FRAC_BITS;

    localparam logic [1:0] BUF_NONE = 2'd0;
    localparam logic [1:0] BUF_ONE  = 2'd1;
    localparam logic [1:0] BUF_TWO  = 2'd2;

    function automatic logic [15:0] limit_dim(input logic [15:0] v, input logic [15:0] maxv);
        if (v == 16'd0) begin
            return 16'd1;
        end else if (v > maxv) begin
            return maxv;
        end
        return v;
    endfunction

    // ---------------- configuration ----------------
    logic [SW_W-1:0] r_src_w, n_src_w;
    logic [SH_W-1:0] r_src_h, n_src_h;
    logic [TD_W-1:0] r_dst_w, n_dst_w;
    logic [TD_W-1:0] r_dst_h, n_dst_h;
    logic [15:0]     lim_sw, lim_sh, lim_tw, lim_th;

    always_comb begin
        lim_sw  = limit_dim(16'(i_cfg_data[SRC_CFG_W-1:0]), 16'(MAX_SRC_WIDTH));
        lim_sh  = limit_dim(16'(i_cfg_data[SRC_CFG_W-1:0]), 16'(MAX_SRC_HEIGHT));
        lim_tw  = limit_dim(16'(i_cfg_data[DST_CFG_W-1:0]), 16'(MAX_DEST_DIM));
        lim_th  = lim_tw;
        n_src_w = lim_sw[SW_W-1:0];
        n_src_h = lim_sh[SH_W-1:0];
        n_dst_w = lim_tw[TD_W-1:0];
        n_dst_h = lim_th[TD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= SW_W'(SRC_W_RST);
            r_src_h <= SH_W'(SRC_H_RST);
            r_dst_w <= TD_W'(DST_RST);
            r_dst_h <= TD_W'(DST_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SRC_WIDTH:  r_src_w <= n_src_w;
                CFG_SRC_HEIGHT: r_src_h <= n_src_h;
                CFG_DST_WIDTH:  r_dst_w <= n_dst_w;
                CFG_DST_HEIGHT: r_dst_h <= n_dst_h;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline advance and output queue ----------------
    logic [1:0]       r_cnt, n_cnt;
    logic [PIX_W-1:0] r_buf0, n_buf0, r_buf1, n_buf1;
    logic             en, push, pop;
    logic [PIX_W-1:0] n_val;
    logic             r_t_vld;

    // whole pipeline moves together; it only holds when both queue slots are taken
    assign en            = (r_cnt != BUF_TWO);
    assign s_axis_tready = en;
    assign push          = en && r_t_vld;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = (r_cnt != BUF_NONE);
    assign m_axis_tdata  = r_buf0;

    always_comb begin
        n_cnt  = r_cnt;
        n_buf0 = r_buf0;
        n_buf1 = r_buf1;
        case (r_cnt)
            BUF_NONE: begin
                if (push) begin
                    n_cnt  = BUF_ONE;
                    n_buf0 = n_val;
                end
            end
            BUF_ONE: begin
                if (push && pop) begin
                    n_buf0 = n_val;
                end else if (push) begin
                    n_cnt  = BUF_TWO;
                    n_buf1 = n_val;
                end else if (pop) begin
                    n_cnt  = BUF_NONE;
                end
            end
            BUF_TWO: begin
                if (pop) begin
                    n_cnt  = BUF_ONE;
                    n_buf0 = r_buf1;
                end
            end
            default: n_cnt = BUF_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= BUF_NONE;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf0 <= n_buf0;
        r_buf1 <= n_buf1;
    end

    // ---------------- stage 1: scale coordinates by source size ----------------
    logic [COORD_W-1:0] in_x, in_y;
    logic [PIX_W-1:0]   in_pix;
    logic [PX_W-1:0]    n_prod_x;
    logic [PY_W-1:0]    n_prod_y;
    t_ctl               n_s1_ctl, r_s1_ctl;
    logic               r_s1_vld;
    logic [DIV_W-1:0]   r_s1_num_x, r_s1_num_y;

    assign in_x   = s_axis_tdata[COORD_W-1:0];
    assign in_y   = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign in_pix = s_axis_tdata[2*COORD_W+PIX_W-1:2*COORD_W];

    always_comb begin
        n_prod_x       = PX_W'(in_x) * PX_W'(r_src_w);
        n_prod_y       = PY_W'(in_y) * PY_W'(r_src_h);
        n_s1_ctl.cmd   = s_axis_tuser;
        n_s1_ctl.wr_ok = (int'(in_x) < MAX_SRC_WIDTH) && (int'(in_y) < MAX_SRC_HEIGHT);
        n_s1_ctl.lx    = XA_W'(in_x);
        n_s1_ctl.ly    = YA_W'(in_y);
        n_s1_ctl.pix   = in_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ctl   <= n_s1_ctl;
            r_s1_num_x <= DIV_W'(n_prod_x) << FRAC_BITS;
            r_s1_num_y <= DIV_W'(n_prod_y) << FRAC_BITS;
        end
    end

    // ---------------- divider stages ----------------
    logic             div_vld;
    t_ctl             div_ctl;
    logic [DIV_W-1:0] div_quo_x, div_quo_y;

    bis_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_s1_vld),
        .i_ctl   (r_s1_ctl),
        .i_num_x (r_s1_num_x),
        .i_num_y (r_s1_num_y),
        .i_den_x (r_dst_w),
        .i_den_y (r_dst_h),
        .o_vld   (div_vld),
        .o_ctl   (div_ctl),
        .o_quo_x (div_quo_x),
        .o_quo_y (div_quo_y)
    );

    // ---------------- clamp stage: neighbour indices and weights ----------------
    logic [IP_W-1:0]      ix, iy;
    logic [SW_W-1:0]      lim_x;
    logic [SH_W-1:0]      lim_y;
    logic [XA_W-1:0]      n_c_x0, n_c_x1, r_c_x0, r_c_x1;
    logic [YA_W-1:0]      n_c_y0, n_c_y1, r_c_y0, r_c_y1;
    logic [FRAC_BITS-1:0] r_c_wx, r_c_wy;
    logic                 r_c_vld;
    t_ctl                 r_c_ctl;

    always_comb begin
        ix    = div_quo_x[DIV_W-1:FRAC_BITS];
        iy    = div_quo_y[DIV_W-1:FRAC_BITS];
        lim_x = r_src_w - SW_W'(1);
        lim_y = r_src_h - SH_W'(1);
        // at or past the last column both neighbours are the edge pixel
        if (ix >= IP_W'(lim_x)) begin
            n_c_x0 = XA_W'(lim_x);
            n_c_x1 = XA_W'(lim_x);
        end else begin
            n_c_x0 = XA_W'(ix);
            n_c_x1 = XA_W'(ix + IP_W'(1));
        end
        if (iy >= IP_W'(lim_y)) begin
            n_c_y0 = YA_W'(lim_y);
            n_c_y1 = YA_W'(lim_y);
        end else begin
            n_c_y0 = YA_W'(iy);
            n_c_y1 = YA_W'(iy + IP_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_ctl <= div_ctl;
            r_c_x0  <= n_c_x0;
            r_c_x1  <= n_c_x1;
            r_c_y0  <= n_c_y0;
            r_c_y1  <= n_c_y1;
            r_c_wx  <= div_quo_x[FRAC_BITS-1:0];
            r_c_wy  <= div_quo_y[FRAC_BITS-1:0];
        end
    end

    // ---------------- store stage: load words write, compute words read ----------------
    logic                 st_wr;
    logic [PIX_W-1:0]     st_nw, st_ne, st_sw, st_se;
    logic                 r_m_vld;
    logic [FRAC_BITS-1:0] r_m_wx, r_m_wy;

    assign st_wr = en && r_c_vld && (r_c_ctl.cmd == CMD_LOAD) && r_c_ctl.wr_ok;

    bis_store u_store (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_wr   (st_wr),
        .i_wx   (r_c_ctl.lx),
        .i_wy   (r_c_ctl.ly),
        .i_wpix (r_c_ctl.pix),
        .i_x0   (r_c_x0),
        .i_x1   (r_c_x1),
        .i_y0   (r_c_y0),
        .i_y1   (r_c_y1),
        .o_nw   (st_nw),
        .o_ne   (st_ne),
        .o_sw   (st_sw),
        .o_se   (st_se)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (en) begin
            r_m_vld <= r_c_vld && (r_c_ctl.cmd == CMD_COMPUTE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_wx <= r_c_wx;
            r_m_wy <= r_c_wy;
        end
    end

    // ---------------- horizontal blend ----------------
    logic [WT_W-1:0]      omx, omy;
    logic [TOP_W-1:0]     nw_e, ne_e, sw_e, se_e, omx_e, wx_e;
    logic [TOP_W-1:0]     n_t_top, n_t_bot, r_t_top, r_t_bot;
    logic [FRAC_BITS-1:0] r_t_wy;

    always_comb begin
        omx     = WT_W'(ONE) - WT_W'(r_m_wx);
        nw_e    = TOP_W'(st_nw);
        ne_e    = TOP_W'(st_ne);
        sw_e    = TOP_W'(st_sw);
        se_e    = TOP_W'(st_se);
        omx_e   = TOP_W'(omx);
        wx_e    = TOP_W'(r_m_wx);
        n_t_top = nw_e * omx_e + ne_e * wx_e;
        n_t_bot = sw_e * omx_e + se_e * wx_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_vld <= 1'b0;
        end else if (en) begin
            r_t_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t_top <= n_t_top;
            r_t_bot <= n_t_bot;
            r_t_wy  <= r_m_wy;
        end
    end

    // ---------------- vertical blend into the output queue ----------------
    logic [ACC_W-1:0] top_e, bot_e, omy_e, wy_e, acc;

    always_comb begin
        omy   = WT_W'(ONE) - WT_W'(r_t_wy);
        top_e = ACC_W'(r_t_top);
        bot_e = ACC_W'(r_t_bot);
        omy_e = ACC_W'(omy);
        wy_e  = ACC_W'(r_t_wy);
        acc   = top_e * omy_e + bot_e * wy_e;
        n_val = acc[ACC_W-1 -: PIX_W];
    end

endmodule
